>>> src/cbordec_pkg.sv
// package for the cbor item stream decoder
// holds the phase encoding, result kind codes, head constants and the result struct
// no dependencies
package cbordec_pkg;

   typedef enum logic [1:0] {
      PH_HEAD    = 2'd0,
      PH_ARG     = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   localparam logic [1:0] KIND_HEAD    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [4:0] AI_MAX_DIRECT = 5'd23;
   localparam logic [4:0] AI_ONE        = 5'h18;
   localparam logic [4:0] AI_TWO        = 5'h19;
   localparam logic [4:0] AI_FOUR       = 5'h1A;

   localparam logic [2:0] MT_BYTE_STRING = 3'd2;
   localparam logic [2:0] MT_TEXT_STRING = 3'd3;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [2:0]  major_type;
      logic [31:0] argument;
      logic [7:0]  data_byte;
      logic        last_payload;
   } result_type;

endpackage

>>> src/cbordec_step.sv
// decode step of the cbor item stream decoder
// holds the parse state and turns one registered byte into at most one result
// depends on cbordec_pkg
module cbordec_step
   import cbordec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] in_byte,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  item_type_ff, item_type_in;
   logic [2:0]  arg_left_ff, arg_left_in;
   logic [31:0] arg_accum_ff, arg_accum_in;
   logic [31:0] payload_left_ff, payload_left_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEAD;
         item_type_ff    <= 3'd0;
         arg_left_ff     <= 3'd0;
         arg_accum_ff    <= 32'd0;
         payload_left_ff <= 32'd0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         item_type_ff    <= item_type_in;
         arg_left_ff     <= arg_left_in;
         arg_accum_ff    <= arg_accum_in;
         payload_left_ff <= payload_left_in;
      end
   end

   logic [4:0]  ai;
   logic [2:0]  head_type;
   logic [31:0] accum_next;
   logic [2:0]  left_next;
   logic [31:0] payload_next;
   logic [31:0] fin_arg;
   logic [2:0]  fin_type;
   logic        fin;

   assign ai           = in_byte[4:0];
   assign head_type    = in_byte[7:5];
   assign accum_next   = {arg_accum_ff[23:0], in_byte};
   assign left_next    = (arg_left_ff != 3'd0) ? arg_left_ff - 3'd1 : 3'd0;
   assign payload_next = (payload_left_ff != 32'd0) ? payload_left_ff - 32'd1 : 32'd0;

   always_comb begin
      phase_in        = phase_ff;
      item_type_in    = item_type_ff;
      arg_left_in     = arg_left_ff;
      arg_accum_in    = arg_accum_ff;
      payload_left_in = payload_left_ff;
      result          = '0;
      fin             = 1'b0;
      fin_arg         = 32'd0;
      fin_type        = item_type_ff;

      case (phase_ff)
         PH_ARG: begin
            arg_accum_in = accum_next;
            arg_left_in  = left_next;
            if (left_next == 3'd0) begin
               fin     = 1'b1;
               fin_arg = accum_next;
            end
         end
         PH_PAYLOAD: begin
            result.valid        = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.major_type   = item_type_ff;
            result.data_byte    = in_byte;
            result.last_payload = (payload_left_ff <= 32'd1);
            payload_left_in     = payload_next;
            if (payload_next == 32'd0) begin
               phase_in = PH_HEAD;
            end
         end
         default: begin
            // head byte, also taken for the unused phase code
            item_type_in = head_type;
            fin_type     = head_type;
            arg_accum_in = 32'd0;
            arg_left_in  = 3'd0;
            if (ai <= AI_MAX_DIRECT) begin
               fin     = 1'b1;
               fin_arg = {27'd0, ai};
            end else if (ai == AI_ONE) begin
               arg_left_in = 3'd1;
               phase_in    = PH_ARG;
            end else if (ai == AI_TWO) begin
               arg_left_in = 3'd2;
               phase_in    = PH_ARG;
            end else if (ai == AI_FOUR) begin
               arg_left_in = 3'd4;
               phase_in    = PH_ARG;
            end else begin
               phase_in          = PH_HEAD;
               result.valid      = 1'b1;
               result.kind       = KIND_ERROR;
               result.major_type = head_type;
               result.argument   = {27'd0, ai};
            end
         end
      endcase

      // head complete: token out, strings with a nonzero length go to payload
      if (fin) begin
         result.valid      = 1'b1;
         result.kind       = KIND_HEAD;
         result.major_type = fin_type;
         result.argument   = fin_arg;
         if ((fin_type == MT_BYTE_STRING || fin_type == MT_TEXT_STRING)
             && fin_arg != 32'd0) begin
            payload_left_in = fin_arg;
            phase_in        = PH_PAYLOAD;
         end else begin
            phase_in = PH_HEAD;
         end
      end
   end

endmodule

>>> src/cbordec_out.sv
// result register of the cbor item stream decoder
// holds one finished result until the response side takes it
// depends on cbordec_pkg
module cbordec_out
   import cbordec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   input  logic       rsp_ready,
   output logic       out_free,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_major_type,
   output logic [31:0] rsp_argument,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last_payload
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = data_ff.kind;
   assign rsp_major_type   = data_ff.major_type;
   assign rsp_argument     = data_ff.argument;
   assign rsp_data_byte    = data_ff.data_byte;
   assign rsp_last_payload = data_ff.last_payload;

endmodule

>>> src/cbor_item_stream_decoder_core.sv
// top level of the cbor item stream decoder
// input byte register, decode step and result register
// depends on cbordec_pkg, cbordec_step and cbordec_out
//
// Decodes a CBOR byte stream, one byte per request, into head tokens (major type and
// argument), string payload bytes with a last mark, and errors for additional info
// 27 to 31. Argument bytes that follow a head give no response; the head token comes
// with the last of them. The block takes one byte every cycle when the response side
// keeps up; a byte passes through the input register and then the result register
// on its way to the response port. The parse state, updated between those two
// registers on each advance, sets the rate.
module cbor_item_stream_decoder_core
   import cbordec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_major_type,
   output logic [31:0] rsp_argument,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last_payload
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_free;
   logic       advance;
   result_type result;

   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   cbordec_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   cbordec_out u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (advance && result.valid),
      .result           (result),
      .rsp_ready        (rsp_ready),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_major_type   (rsp_major_type),
      .rsp_argument     (rsp_argument),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last_payload (rsp_last_payload)
   );

endmodule
